/* src/adb_pkg.sv */
package adb_pkg;

  localparam int unsigned HoldWidth = 20;
  localparam int unsigned DurWidth  = 8;

  localparam logic [HoldWidth-1:0] LONG_PRESS_RESET = 20'd500000;
  localparam logic [DurWidth-1:0]  DUR_MAX          = 8'd255;
  localparam logic [DurWidth-1:0]  DUR_MIN          = 8'd1;

  // button phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_HELD    = 2'd2;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic                 button_on_level;
    logic                 button_off_level;
  } req_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [DurWidth-1:0]  dur;
    logic [HoldWidth-1:0] hold;
    logic                 restart;
  } btn_upd_t;

endpackage

/* src/adb_if.sv */
interface adb_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic button_on_level;
  logic button_off_level;

  modport source (output valid, output req_type, output button_on_level,
                  output button_off_level, input ready);
  modport sink   (input valid, input req_type, input button_on_level,
                  input button_off_level, output ready);
endinterface

interface adb_rsp_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic       toggled;
  logic [7:0] on_seconds;
  logic [7:0] off_seconds;

  modport source (output valid, output led_on, output toggled, output on_seconds,
                  output off_seconds, input ready);
  modport sink   (input valid, input led_on, input toggled, input on_seconds,
                  input off_seconds, output ready);
endinterface

/* src/adb_button.sv */
module adb_button (
  input  logic                             poll_i,
  input  logic                             level_i,
  input  logic [1:0]                       phase_i,
  input  logic [adb_pkg::DurWidth-1:0]     dur_i,
  input  logic [adb_pkg::HoldWidth-1:0]    hold_i,
  input  logic [adb_pkg::HoldWidth-1:0]    long_press_i,
  output adb_pkg::btn_upd_t                upd_o
);

  logic                          pressed;
  logic [adb_pkg::HoldWidth-1:0] hold_inc;

  assign pressed  = ~level_i;
  assign hold_inc = hold_i + adb_pkg::HoldWidth'(1);

  always_comb begin
    upd_o.phase   = phase_i;
    upd_o.dur     = dur_i;
    upd_o.hold    = hold_i;
    upd_o.restart = 1'b0;
    if (poll_i) begin
      unique case (phase_i)
        adb_pkg::PH_PRESSED: begin
          upd_o.phase = pressed ? adb_pkg::PH_HELD : adb_pkg::PH_IDLE;
        end
        adb_pkg::PH_HELD: begin
          if (pressed) begin
            upd_o.hold = hold_inc;
            if (hold_inc >= long_press_i) begin
              upd_o.dur     = adb_pkg::DUR_MIN;
              upd_o.hold    = '0;
              upd_o.restart = 1'b1;
            end
          end else begin
            upd_o.phase = adb_pkg::PH_IDLE;
            upd_o.hold  = '0;
          end
        end
        default: begin
          // idle, and the unused code handled as idle
          upd_o.phase = adb_pkg::PH_IDLE;
          if (pressed) begin
            if (dur_i != adb_pkg::DUR_MAX) begin
              upd_o.dur = dur_i + adb_pkg::DurWidth'(1);
            end
            upd_o.phase = adb_pkg::PH_PRESSED;
          end
        end
      endcase
    end
  end

endmodule

/* src/adjustable_duty_blinker.sv */
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless a held response stalls it; the
// state update is one short combinational pass from input to result register.
// Reset: rst_ni is asynchronous, active low; LED off, durations 1, long press 500000.
module adjustable_duty_blinker #(
  parameter int unsigned ELAPSED_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  adb_req_if.sink                       req_i,
  adb_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [adb_pkg::HoldWidth-1:0] cfg_wdata_i
);

  logic                          s1_valid_q;
  adb_pkg::req_t                 s1_req_q;
  logic                          fire;

  logic [adb_pkg::HoldWidth-1:0] long_press_q;
  logic                          led_q, led_d;
  logic [ELAPSED_WIDTH-1:0]      elapsed_q, elapsed_d, elapsed_inc, limit;
  logic [adb_pkg::DurWidth-1:0]  on_dur_q, off_dur_q;
  logic [1:0]                    on_phase_q, off_phase_q;
  logic [adb_pkg::HoldWidth-1:0] on_hold_q, off_hold_q;
  logic                          toggled_d;
  logic                          poll;

  adb_pkg::btn_upd_t             on_upd, off_upd;

  logic                          rsp_valid_q;
  logic                          rsp_led_q, rsp_tog_q;
  logic [adb_pkg::DurWidth-1:0]  rsp_on_q, rsp_off_q;

  assign fire        = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || fire;
  assign poll        = (s1_req_q.req_type == adb_pkg::REQ_POLL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q.req_type         <= req_i.req_type;
      s1_req_q.button_on_level  <= req_i.button_on_level;
      s1_req_q.button_off_level <= req_i.button_off_level;
    end
  end

  adb_button u_on_btn (
    .poll_i       (poll),
    .level_i      (s1_req_q.button_on_level),
    .phase_i      (on_phase_q),
    .dur_i        (on_dur_q),
    .hold_i       (on_hold_q),
    .long_press_i (long_press_q),
    .upd_o        (on_upd)
  );

  adb_button u_off_btn (
    .poll_i       (poll),
    .level_i      (s1_req_q.button_off_level),
    .phase_i      (off_phase_q),
    .dur_i        (off_dur_q),
    .hold_i       (off_hold_q),
    .long_press_i (long_press_q),
    .upd_o        (off_upd)
  );

  assign elapsed_inc = elapsed_q + ELAPSED_WIDTH'(1);
  assign limit       = ELAPSED_WIDTH'(led_q ? on_dur_q : off_dur_q);

  always_comb begin
    led_d     = led_q;
    elapsed_d = elapsed_q;
    toggled_d = 1'b0;
    if (!poll) begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc >= limit) begin
        led_d     = ~led_q;
        elapsed_d = '0;
        toggled_d = 1'b1;
      end
    end else if (on_upd.restart || off_upd.restart) begin
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= adb_pkg::LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      long_press_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q       <= 1'b0;
      elapsed_q   <= '0;
      on_dur_q    <= adb_pkg::DUR_MIN;
      off_dur_q   <= adb_pkg::DUR_MIN;
      on_phase_q  <= adb_pkg::PH_IDLE;
      off_phase_q <= adb_pkg::PH_IDLE;
      on_hold_q   <= '0;
      off_hold_q  <= '0;
    end else if (fire) begin
      led_q       <= led_d;
      elapsed_q   <= elapsed_d;
      on_dur_q    <= on_upd.dur;
      off_dur_q   <= off_upd.dur;
      on_phase_q  <= on_upd.phase;
      off_phase_q <= off_upd.phase;
      on_hold_q   <= on_upd.hold;
      off_hold_q  <= off_upd.hold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_led_q <= led_d;
      rsp_tog_q <= toggled_d;
      rsp_on_q  <= on_upd.dur;
      rsp_off_q <= off_upd.dur;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.led_on      = rsp_led_q;
  assign rsp_o.toggled     = rsp_tog_q;
  assign rsp_o.on_seconds  = rsp_on_q;
  assign rsp_o.off_seconds = rsp_off_q;

`ifndef SYNTH
  a_elapsed_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q < limit)
    else $error("elapsed counter reached phase duration");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_phase_q != adb_pkg::PH_UNUSED && off_phase_q != adb_pkg::PH_UNUSED)
    else $error("button phase in unused code");

  a_toggle_flips_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && toggled_d |=> led_q != $past(led_q))
    else $error("toggle without LED change");

  a_dur_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.on_seconds != 8'd0 && rsp_o.off_seconds != 8'd0)
    else $error("zero duration reported");
`endif

endmodule
